// File: hw/rtl/positional_list_engine_core_macros.svh
// assertion helpers for the list engine core
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PLEL_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define PLEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/plel_pkg.sv
package plel_pkg;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned POS_W     = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_OUT_W = 6;
  // wide enough for position and count plus one
  localparam int unsigned CMP_W     = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  typedef enum logic [2:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ_FWD  = 3'd6,
    CMD_READ_BACK = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_RESP,
    S_RD_ISSUE,
    S_RD_CAP
  } state_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    stat_e                   status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
    logic [CNT_OUT_W-1:0]    entry_count;
  } rsp_t;

endpackage

// File: hw/rtl/plel_stream_if.sv
interface plel_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: hw/rtl/plel_ram.sv
module plel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/positional_list_engine_core.sv
// Ordered list of up to DEPTH values held in one single-port-read, single-port-write
// RAM with a registered read. Requests insert at the front, the back or a 1-based
// position, delete from the front, the back or a position, or read the whole list
// forward or backward. Inserts and deletes give one response with a status and the
// new count; a read gives one response per entry, the final one marked last, and an
// empty list read gives a single empty-status response. A rejected request leaves the
// list untouched. An insert moves each entry at or above the target slot up one slot,
// then drains the last move and puts the new value; an insert at the back writes
// directly, and a delete moves each entry above the target slot down one slot. A read
// issues a RAM read and captures it into the response register for each entry. Reset
// clears the state, the count and the valid flags but not the RAM; no clearing pass
// over the RAM is needed since only slots below the count are read.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core import plel_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  plel_stream_if.sink   req_i,
  plel_stream_if.source rsp_o
);

  // control and datapath registers
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;       // entries held
  logic [IDX_W-1:0]      ptr_q, ptr_d;       // shift source / read address
  logic [IDX_W-1:0]      idx_q, idx_d;       // target slot of an insert
  logic [DATA_WIDTH-1:0] val_q, val_d;       // value waiting to be put
  logic [CNT_W-1:0]      rem_q, rem_d;       // read responses still to go
  logic                  bwd_q, bwd_d;       // read walks back to front
  stat_e                 stat_q, stat_d;
  logic                  wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0]      wr_addr_q, wr_addr_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  // ram port
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // request decode
  logic                  req_fire;
  cmd_e                  cmd;
  logic [CMP_W-1:0]      pos_x, cnt_x;
  logic                  full, empty, out_free;
  logic [IDX_W-1:0]      tail_idx, pos_idx;
  logic                  dec_ins, dec_del, dec_rd, dec_bwd, dec_shift;
  stat_e                 dec_stat;
  logic [IDX_W-1:0]      dec_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cmd         = req_i.data.command;
  assign pos_x       = CMP_W'(req_i.data.position);
  assign cnt_x       = CMP_W'(cnt_q);
  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign empty       = (cnt_q == '0);
  assign tail_idx    = IDX_W'(cnt_q - 1'b1);
  assign pos_idx     = IDX_W'(req_i.data.position - 1'b1);
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_comb begin
    dec_ins  = 1'b0;
    dec_del  = 1'b0;
    dec_rd   = 1'b0;
    dec_bwd  = 1'b0;
    dec_stat = STAT_OK;
    dec_idx  = '0;
    unique case (cmd)
      CMD_INS_FIRST: begin
        dec_ins = 1'b1;
      end
      CMD_INS_LAST: begin
        dec_ins = 1'b1;
        dec_idx = IDX_W'(cnt_q);
      end
      CMD_INS_POS: begin
        dec_ins = 1'b1;
        dec_idx = pos_idx;
        if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
          dec_stat = STAT_BAD_POS;
        end
      end
      CMD_DEL_FIRST: begin
        dec_del = 1'b1;
      end
      CMD_DEL_LAST: begin
        dec_del = 1'b1;
        dec_idx = tail_idx;
      end
      CMD_DEL_POS: begin
        dec_del = 1'b1;
        dec_idx = pos_idx;
        if (pos_x == '0 || pos_x > cnt_x) begin
          dec_stat = STAT_BAD_POS;
        end
      end
      CMD_READ_FWD: begin
        dec_rd = 1'b1;
      end
      CMD_READ_BACK: begin
        dec_rd  = 1'b1;
        dec_bwd = 1'b1;
      end
    endcase
    // capacity checks take priority over the position check
    if (dec_ins && full) begin
      dec_stat = STAT_FULL;
    end
    if ((dec_del || dec_rd) && empty) begin
      dec_stat = STAT_EMPTY;
    end
  end

  // an insert at or below the tail or a delete below it has entries to move
  assign dec_shift = dec_ins ? (CNT_W'(dec_idx) != cnt_q)
                             : (CNT_W'(dec_idx) + 1'b1 != cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (dec_stat != STAT_OK) begin
            state_d = S_RESP;
          end else if (dec_rd) begin
            state_d = S_RD_ISSUE;
          end else if (dec_ins) begin
            state_d = dec_shift ? S_INS_SHIFT : S_RESP;
          end else begin
            state_d = dec_shift ? S_DEL_SHIFT : S_RESP;
          end
        end
      end
      S_INS_SHIFT: begin
        if (ptr_q == idx_q) begin
          state_d = S_INS_DRAIN;
        end
      end
      S_INS_DRAIN: begin
        state_d = S_INS_PUT;
      end
      S_INS_PUT: begin
        state_d = S_RESP;
      end
      S_DEL_SHIFT: begin
        if (ptr_q == tail_idx) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        if (out_free) begin
          state_d = S_RD_CAP;
        end
      end
      S_RD_CAP: begin
        state_d = (rem_q == CNT_W'(1)) ? S_IDLE : S_RD_ISSUE;
      end
    endcase
  end

  // datapath, ram port and response register
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    rem_d       = rem_q;
    bwd_d       = bwd_q;
    stat_d      = stat_q;
    wr_addr_d   = wr_addr_q;
    wr_pend_d   = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    // a moved entry lands in the cycle after its read
    ram_we      = wr_pend_q;
    ram_waddr   = wr_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          stat_d = dec_stat;
          idx_d  = dec_idx;
          val_d  = DATA_WIDTH'($unsigned(req_i.data.value));
          bwd_d  = dec_bwd;
          rem_d  = cnt_q;
          if (dec_stat == STAT_OK) begin
            if (dec_rd) begin
              ptr_d = dec_bwd ? tail_idx : '0;
            end else if (dec_ins) begin
              if (dec_shift) begin
                ptr_d = tail_idx;
              end else begin
                // append at the tail needs no move
                ram_we    = 1'b1;
                ram_waddr = dec_idx;
                ram_wdata = DATA_WIDTH'($unsigned(req_i.data.value));
                cnt_d     = cnt_q + 1'b1;
              end
            end else begin
              if (dec_shift) begin
                ptr_d = dec_idx + 1'b1;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end
        end
      end
      S_INS_SHIFT: begin
        // walk down from the tail, each entry moves up one slot
        ram_re    = 1'b1;
        wr_pend_d = 1'b1;
        wr_addr_d = ptr_q + 1'b1;
        if (ptr_q != idx_q) begin
          ptr_d = ptr_q - 1'b1;
        end
      end
      S_INS_DRAIN: begin
        // last moved entry is written this cycle
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = val_q;
        cnt_d     = cnt_q + 1'b1;
      end
      S_DEL_SHIFT: begin
        // walk up from the hole, each entry moves down one slot
        ram_re    = 1'b1;
        wr_pend_d = 1'b1;
        wr_addr_d = ptr_q - 1'b1;
        if (ptr_q == tail_idx) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = stat_q;
          out_d.entry_value = '0;
          out_d.last        = 1'b1;
          out_d.entry_count = CNT_OUT_W'(cnt_q);
        end
      end
      S_RD_ISSUE: begin
        ram_re = out_free;
      end
      S_RD_CAP: begin
        out_valid_d       = 1'b1;
        out_d.status      = STAT_OK;
        out_d.entry_value = VAL_W'(ram_rdata);
        out_d.last        = (rem_q == CNT_W'(1));
        out_d.entry_count = CNT_OUT_W'(cnt_q);
        rem_d             = rem_q - 1'b1;
        if (rem_q != CNT_W'(1)) begin
          ptr_d = bwd_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    rem_q     <= rem_d;
    bwd_q     <= bwd_d;
    stat_q    <= stat_d;
    wr_addr_q <= wr_addr_d;
    out_q     <= out_d;
  end

  plel_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  `PLEL_ASSERT_NOW(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `PLEL_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "shift read hits write slot")
  `PLEL_ASSERT_IMP(a_put_port_free, state_q == S_INS_PUT, !wr_pend_q, "put collides with moved entry")
  `PLEL_ASSERT_NXT(a_read_keeps_count, state_q == S_RD_CAP, $stable(cnt_q), "count changed during read")
  `PLEL_ASSERT_NXT(a_last_ends_read, state_q == S_RD_CAP && rem_q == CNT_W'(1), state_q == S_IDLE && out_valid_q && out_q.last, "read did not end on last")

endmodule

// File: verif/positional_list_engine_core_test.sv
module positional_list_engine_core_test;
  import plel_pkg::*;

  typedef enum int unsigned {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  // receiver hold-off length, in cycles
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned ITEMS_PER_PH  = 42;
  localparam int unsigned DRAIN_CYCLES  = 100;

  // mirrors the list contents and queues up the responses each request must give
  class list_tracker;
    logic signed [VAL_W-1:0] held_values[$];
    rsp_t                    pending_rsps[$];
    int unsigned             mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned held_count();
      return held_values.size();
    endfunction

    function int unsigned pending_count();
      return pending_rsps.size();
    endfunction

    function void push_rsp(stat_e st, logic signed [VAL_W-1:0] v, logic lst);
      rsp_t r;
      r.status      = st;
      r.entry_value = v;
      r.last        = lst;
      r.entry_count = CNT_OUT_W'(held_values.size());
      pending_rsps.push_back(r);
    endfunction

    function void note_request(req_t r);
      int unsigned n;
      int unsigned p;
      stat_e       st;
      n  = held_values.size();
      p  = r.position;
      st = STAT_OK;
      case (r.command)
        CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
          // full is checked ahead of the position
          if (n >= DEPTH) begin
            st = STAT_FULL;
          end else if (r.command == CMD_INS_FIRST) begin
            held_values.push_front(r.value);
          end else if (r.command == CMD_INS_LAST) begin
            held_values.push_back(r.value);
          end else if (p < 1 || p > n + 1) begin
            st = STAT_BAD_POS;
          end else if (p == n + 1) begin
            held_values.push_back(r.value);
          end else begin
            held_values.insert(p - 1, r.value);
          end
          push_rsp(st, '0, 1'b1);
        end
        CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
          // empty is checked ahead of the position
          if (n == 0) begin
            st = STAT_EMPTY;
          end else if (r.command == CMD_DEL_FIRST) begin
            void'(held_values.pop_front());
          end else if (r.command == CMD_DEL_LAST) begin
            void'(held_values.pop_back());
          end else if (p < 1 || p > n) begin
            st = STAT_BAD_POS;
          end else begin
            held_values.delete(p - 1);
          end
          push_rsp(st, '0, 1'b1);
        end
        default: begin
          if (n == 0) begin
            push_rsp(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              push_rsp(STAT_OK,
                       held_values[(r.command == CMD_READ_FWD) ? i : n - 1 - i],
                       (i + 1 == n));
            end
          end
        end
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected response status %0d value %0d last %0b count %0d",
                 $time, got.status, got.entry_value, got.last, got.entry_count);
        mismatches++;
        return;
      end
      want = pending_rsps.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
      if (got.entry_value !== want.entry_value) begin
        $display("%0t: entry_value mismatch, expected %0d actual %0d",
                 $time, want.entry_value, got.entry_value);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0b actual %0b",
                 $time, want.last, got.last);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch, expected %0d actual %0d",
                 $time, want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  plel_stream_if #(.payload_t(req_t)) req_if ();
  plel_stream_if #(.payload_t(rsp_t)) rsp_if ();

  positional_list_engine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  list_tracker tracker = new();
  bit          idle_on;
  bit          hold_pending;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic req_t make_req(cmd_e c, logic signed [VAL_W-1:0] v,
                                    logic [POS_W-1:0] p);
    req_t r;
    r.command  = c;
    r.value    = v;
    r.position = p;
    return r;
  endfunction

  // biased toward the extremes now and then
  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request(phase_e ph, int unsigned n);
    req_t        r;
    int unsigned roll;
    int unsigned ins_lim;
    int unsigned lim;
    roll    = $urandom_range(0, 99);
    ins_lim = (ph == PH_FILL) ? 70 : (ph == PH_DRAIN) ? 20 : 45;
    if (roll < ins_lim) begin
      case ($urandom_range(0, 2))
        0:       r.command = CMD_INS_FIRST;
        1:       r.command = CMD_INS_LAST;
        default: r.command = CMD_INS_POS;
      endcase
    end else if (roll < 87) begin
      case ($urandom_range(0, 2))
        0:       r.command = CMD_DEL_FIRST;
        1:       r.command = CMD_DEL_LAST;
        default: r.command = CMD_DEL_POS;
      endcase
    end else begin
      r.command = $urandom_range(0, 1) ? CMD_READ_FWD : CMD_READ_BACK;
    end
    r.value = random_value();
    // mostly legal positions, the rest anywhere from 0 to 33
    if ((r.command == CMD_INS_POS || r.command == CMD_DEL_POS) &&
        $urandom_range(0, 4) != 0) begin
      lim        = (r.command == CMD_INS_POS) ? n + 1 : n;
      r.position = POS_W'($urandom_range(1, (lim == 0) ? 1 : lim));
    end else begin
      r.position = POS_W'($urandom_range(0, 33));
    end
    return r;
  endfunction

  // offer one request from the falling edge on, return once it is taken
  task automatic send_request(req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = r;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(r);
  endtask

  // response side: random stalls per response, one long hold-off on request
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_pending = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      tracker.check_response(rsp_if.data);
    end
  end

  initial begin
    phase_e plan[8];
    plan         = '{PH_FILL, PH_FILL, PH_MIXED, PH_DRAIN, PH_DRAIN,
                     PH_FILL, PH_FILL, PH_MIXED};
    idle_on      = 1'b0;
    hold_pending = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list: reads and every delete flavor
    send_request(make_req(CMD_READ_FWD, '0, 6'd0));
    send_request(make_req(CMD_READ_BACK, '0, 6'd0));
    send_request(make_req(CMD_DEL_FIRST, '0, 6'd0));
    send_request(make_req(CMD_DEL_LAST, '0, 6'd0));
    send_request(make_req(CMD_DEL_POS, '0, 6'd1));
    // bad insert positions on an empty list
    send_request(make_req(CMD_INS_POS, 32'sd5, 6'd0));
    send_request(make_req(CMD_INS_POS, 32'sd5, 6'd2));
    // build up with extreme values
    idle_on = 1'b1;
    send_request(make_req(CMD_INS_FIRST, 32'sh7fffffff, 6'd63));
    send_request(make_req(CMD_INS_LAST, 32'sh80000000, 6'd0));
    send_request(make_req(CMD_INS_POS, 32'sd0, 6'd2));
    send_request(make_req(CMD_INS_POS, -32'sd1, 6'd1));
    send_request(make_req(CMD_INS_POS, 32'sh5a5a5a5a, 6'd5));
    send_request(make_req(CMD_INS_POS, 32'sd7, 6'd7));
    send_request(make_req(CMD_INS_POS, 32'sd7, 6'd33));
    send_request(make_req(CMD_READ_FWD, '0, 6'd0));
    send_request(make_req(CMD_READ_BACK, '0, 6'd0));
    // delete positions out of range, then legal ones
    send_request(make_req(CMD_DEL_POS, '0, 6'd0));
    send_request(make_req(CMD_DEL_POS, '0, 6'd6));
    send_request(make_req(CMD_DEL_POS, '0, 6'd2));
    send_request(make_req(CMD_DEL_FIRST, '0, 6'd0));
    send_request(make_req(CMD_DEL_LAST, '0, 6'd0));
    send_request(make_req(CMD_READ_FWD, '0, 6'd0));
    send_request(make_req(CMD_DEL_POS, '0, 6'd2));
    send_request(make_req(CMD_DEL_POS, '0, 6'd1));
    send_request(make_req(CMD_READ_BACK, '0, 6'd0));

    // random phases push the list toward full and back toward empty; some run gap-free
    foreach (plan[k]) begin
      idle_on = (k % 3 != 2);
      for (int unsigned j = 0; j < ITEMS_PER_PH; j++) begin
        // one long receiver hold-off while requests keep coming
        if (k == 5 && j == 10) begin
          hold_pending = 1'b1;
        end
        send_request(random_request(plan[k], tracker.held_count()));
      end
    end

    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tracker.pending_count() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
